// File: hdl/rgb565_frame_color_statistics_macros.svh
// ----------------------------------------------------------------------------
// RGB565 frame statistics assertion macros
// Shared concurrent assertion forms for the frame statistics checker.
// ----------------------------------------------------------------------------
`ifndef RGB565_FRAME_COLOR_STATISTICS_MACROS_SVH
`define RGB565_FRAME_COLOR_STATISTICS_MACROS_SVH

// Check a consequent in the cycle after the antecedent, outside reset.
`define RFCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Check a consequent in the same cycle as the antecedent, outside reset.
`define RFCS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequent in the cycle after the antecedent, including while reset is applied.
`define RFCS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/rfcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB565 frame statistics package
// Widths, fixed-point constants, sequencer states and channel scaling helpers.
// ----------------------------------------------------------------------------
package rfcs_pkg;

   // Request and response field widths
   localparam int PIXEL_W       = 16;
   localparam int RED_MEAN_W    = 16;
   localparam int RED_OVER_GB_W = 24;
   localparam int LUMA_VAR_W    = 23;
   localparam int PIXEL_TOTAL_W = 16;

   // Frame length limit and pixel counter width
   localparam int MAX_PIXELS = 32768;
   localparam int COUNT_W    = $clog2(MAX_PIXELS + 1);

   // Accumulator widths
   localparam int CHAN_W     = 16;
   localparam int SUM_RED_W  = 32;
   localparam int SUM_GB_W   = 33;
   localparam int SUM_LUMA_W = 32;
   localparam int SUM_SQ_W   = 48;
   localparam int SQ_HALF_W  = SUM_SQ_W / 2;

   // Shared multiplier and divider widths
   localparam int MUL_W       = 32;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int DIV_W       = 64;
   localparam int DEN_W       = 40;
   localparam int DIV_CNT_W   = $clog2(DIV_W);
   localparam int VAR_SCALE_W = 8;
   localparam int RATIO_FRAC_W = 16;

   // BT.601 luma weights in Q0.16 and rounding offset
   localparam logic [MUL_W-1:0] LUMA_W_RED   = 32'd19595;
   localparam logic [MUL_W-1:0] LUMA_W_GREEN = 32'd38470;
   localparam logic [MUL_W-1:0] LUMA_W_BLUE  = 32'd7471;
   localparam logic [MUL_W-1:0] LUMA_ROUND   = 32'h0000_8000;

   // 1.0 in Q8.8 added to the ratio denominator
   localparam logic [DEN_W-1:0] RATIO_ONE = 40'd256;

   // Sequencer states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MUL_RED,
      ST_MUL_GREEN,
      ST_MUL_BLUE,
      ST_LUMA,
      ST_SQUARE,
      ST_ACCUM,
      ST_MEAN_LOAD,
      ST_MEAN_RUN,
      ST_RATIO_PREP,
      ST_RATIO_LOAD,
      ST_RATIO_RUN,
      ST_RATIO_DONE,
      ST_VAR_S1SQ,
      ST_VAR_NLO,
      ST_VAR_NHI,
      ST_VAR_SUMA,
      ST_VAR_NN,
      ST_VAR_DIFF,
      ST_VAR_LOAD,
      ST_VAR_RUN,
      ST_VAR_DONE,
      ST_EMIT
   } state_type;

   // Scale a 5-bit channel to Q8.8: round(c * 255 / 31).
   // 65280 = 31 * 2105 + 25; the fraction uses a reciprocal of 31.
   function automatic logic [CHAN_W-1:0] red_blue_q88(input logic [4:0] c5);
      logic [CHAN_W-1:0] whole;
      logic [9:0]        frac_num;
      logic [21:0]       frac_prod;
      whole     = CHAN_W'(CHAN_W'(c5) * CHAN_W'(2105));
      frac_num  = 10'(10'(c5) * 10'd25 + 10'd15);
      frac_prod = 22'(22'(frac_num) * 22'd2115);
      return CHAN_W'(whole + CHAN_W'(frac_prod[21:16]));
   endfunction

   // Scale a 6-bit channel to Q8.8: round(c * 255 / 63).
   // 65280 = 63 * 1036 + 12; the fraction uses a reciprocal of 63.
   function automatic logic [CHAN_W-1:0] green_q88(input logic [5:0] c6);
      logic [CHAN_W-1:0] whole;
      logic [9:0]        frac_num;
      logic [21:0]       frac_prod;
      whole     = CHAN_W'(CHAN_W'(c6) * CHAN_W'(1036));
      frac_num  = 10'(10'(c6) * 10'd12 + 10'd31);
      frac_prod = 22'(22'(frac_num) * 22'd1041);
      return CHAN_W'(whole + CHAN_W'(frac_prod[21:16]));
   endfunction

endpackage

// File: hdl/rfcs_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB565 frame statistics request channel
// Valid/ready channel carrying one RGB565 pixel and its end-of-frame mark.
// ----------------------------------------------------------------------------
interface rfcs_req_if;
   logic                         valid;
   logic                         ready;
   logic [rfcs_pkg::PIXEL_W-1:0] pixel;
   logic                         last;

   modport source (output valid, output pixel, output last, input ready);
   modport sink   (input valid, input pixel, input last, output ready);
endinterface

// File: hdl/rfcs_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB565 frame statistics response channel
// Valid/ready channel carrying the per-frame color statistics.
// ----------------------------------------------------------------------------
interface rfcs_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [rfcs_pkg::RED_MEAN_W-1:0]    red_mean;
   logic [rfcs_pkg::RED_OVER_GB_W-1:0] red_over_gb;
   logic [rfcs_pkg::LUMA_VAR_W-1:0]    luma_variance;
   logic [rfcs_pkg::PIXEL_TOTAL_W-1:0] pixel_total;

   modport source (output valid, output red_mean, output red_over_gb,
                   output luma_variance, output pixel_total, input ready);
   modport sink   (input valid, input red_mean, input red_over_gb,
                   input luma_variance, input pixel_total, output ready);
endinterface

// File: hdl/rgb565_frame_color_statistics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB565 frame color statistics
// Per-frame red mean, red ratio and luma variance over a stream of pixels.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan takes one big-endian RGB565 pixel per request, with last set on
//   the final pixel of a frame. rsp_chan returns one response per frame: the
//   rounded red mean (Q8.8), red over green-plus-blue-plus-one (Q8.16,
//   saturating), sample luma variance (Q15.8, saturating) and pixel count.
//   Pixels beyond 32768 in a frame are dropped; the frame still closes on last.
// Timing:
//   A pixel occupies the block from MUL_RED through ACCUM: one 32x32
//   multiplier is shared by the three luma weights and the luma square in
//   turn. A last pixel adds the frame close: up to three 64-step restoring
//   divisions on one radix-2 divider plus the n*S2, S1^2 and n*(n-1) products
//   on the multiplier. req_chan.ready is high only while the sequencer is idle.
// Reset and stall:
//   Synchronous reset clears the sums, the count, the sequencer and the
//   response valid. A frame result waits in the response register; the next
//   frame's pixels are taken meanwhile, and only the emit step of that frame
//   holds until the response register is free.
// ----------------------------------------------------------------------------
module rgb565_frame_color_statistics (
   input  logic      clock,
   input  logic      reset,
   rfcs_req_if.sink   req_chan,
   rfcs_rsp_if.source rsp_chan
);

   rfcs_pkg::state_type state_ff, state_in;

   // Frame accumulators
   logic [rfcs_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic [rfcs_pkg::SUM_RED_W-1:0]  sum_red_ff, sum_red_in;
   logic [rfcs_pkg::SUM_GB_W-1:0]   sum_gb_ff, sum_gb_in;
   logic [rfcs_pkg::SUM_LUMA_W-1:0] sum_luma_ff, sum_luma_in;
   logic [rfcs_pkg::SUM_SQ_W-1:0]   sum_sq_ff, sum_sq_in;

   // Current pixel
   logic [rfcs_pkg::CHAN_W-1:0] red_ff, red_in;
   logic [rfcs_pkg::CHAN_W-1:0] green_ff, green_in;
   logic [rfcs_pkg::CHAN_W-1:0] blue_ff, blue_in;
   logic                        last_ff, last_in;
   logic [rfcs_pkg::MUL_W-1:0]  luma_acc_ff, luma_acc_in;

   // Shared multiplier
   logic [rfcs_pkg::MUL_W-1:0]  mul_a, mul_b;
   logic [rfcs_pkg::PROD_W-1:0] mul_out;
   logic [rfcs_pkg::PROD_W-1:0] prod_ff, prod_in;

   // Shared divider
   logic [rfcs_pkg::DIV_W-1:0]     div_quo_ff, div_quo_in;
   logic [rfcs_pkg::DEN_W-1:0]     div_rem_ff, div_rem_in;
   logic [rfcs_pkg::DEN_W-1:0]     div_den_ff, div_den_in;
   logic [rfcs_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [rfcs_pkg::DEN_W:0]       div_shift;
   logic                           div_take;
   logic [rfcs_pkg::DEN_W-1:0]     div_rem_step;
   logic [rfcs_pkg::DIV_W-1:0]     div_quo_step;

   // Variance terms
   logic [rfcs_pkg::DIV_W-1:0] var_a_ff, var_a_in;
   logic [rfcs_pkg::DIV_W-1:0] var_s_ff, var_s_in;
   logic                       var_neg_ff, var_neg_in;
   logic [rfcs_pkg::DIV_W:0]   var_sub;

   // Frame results and response register
   logic [rfcs_pkg::RED_MEAN_W-1:0]    mean_ff, mean_in;
   logic [rfcs_pkg::RED_OVER_GB_W-1:0] ratio_ff, ratio_in;
   logic [rfcs_pkg::LUMA_VAR_W-1:0]    var_ff, var_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [rfcs_pkg::RED_MEAN_W-1:0]    rsp_mean_ff, rsp_mean_in;
   logic [rfcs_pkg::RED_OVER_GB_W-1:0] rsp_ratio_ff, rsp_ratio_in;
   logic [rfcs_pkg::LUMA_VAR_W-1:0]    rsp_var_ff, rsp_var_in;
   logic [rfcs_pkg::PIXEL_TOTAL_W-1:0] rsp_total_ff, rsp_total_in;

   logic req_take;
   logic count_full;
   logic div_done;
   logic rsp_free;

   // Handshake and status
   assign req_chan.ready = (state_ff == rfcs_pkg::ST_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign count_full     = (count_ff == rfcs_pkg::COUNT_W'(rfcs_pkg::MAX_PIXELS));
   assign div_done       = (div_cnt_ff == '0);
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   // Multiply the selected operands
   assign mul_out = rfcs_pkg::PROD_W'(rfcs_pkg::PROD_W'(mul_a) * rfcs_pkg::PROD_W'(mul_b));

   // Advance the restoring divider by one quotient bit
   assign div_shift    = {div_rem_ff, div_quo_ff[rfcs_pkg::DIV_W-1]};
   assign div_take     = (div_shift >= {1'b0, div_den_ff});
   assign div_rem_step = div_take ? rfcs_pkg::DEN_W'(div_shift - {1'b0, div_den_ff})
                                  : div_shift[rfcs_pkg::DEN_W-1:0];
   assign div_quo_step = {div_quo_ff[rfcs_pkg::DIV_W-2:0], div_take};

   // Form n*S2 - S1^2 with its borrow
   assign var_sub = {1'b0, var_a_ff} - {1'b0, var_s_ff};

   // Sequencer: next state, operand selection and register updates
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sum_red_in   = sum_red_ff;
      sum_gb_in    = sum_gb_ff;
      sum_luma_in  = sum_luma_ff;
      sum_sq_in    = sum_sq_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      last_in      = last_ff;
      luma_acc_in  = luma_acc_ff;
      mul_a        = '0;
      mul_b        = '0;
      prod_in      = prod_ff;
      div_quo_in   = div_quo_ff;
      div_rem_in   = div_rem_ff;
      div_den_in   = div_den_ff;
      div_cnt_in   = div_cnt_ff;
      var_a_in     = var_a_ff;
      var_s_in     = var_s_ff;
      var_neg_in   = var_neg_ff;
      mean_in      = mean_ff;
      ratio_in     = ratio_ff;
      var_in       = var_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_mean_in  = rsp_mean_ff;
      rsp_ratio_in = rsp_ratio_ff;
      rsp_var_in   = rsp_var_ff;
      rsp_total_in = rsp_total_ff;

      case (state_ff)
         rfcs_pkg::ST_IDLE: begin
            // Unpack the pixel; drop it when the frame is already full
            if (req_take) begin
               red_in   = rfcs_pkg::red_blue_q88(req_chan.pixel[15:11]);
               green_in = rfcs_pkg::green_q88(req_chan.pixel[10:5]);
               blue_in  = rfcs_pkg::red_blue_q88(req_chan.pixel[4:0]);
               last_in  = req_chan.last;
               if (!count_full) begin
                  state_in = rfcs_pkg::ST_MUL_RED;
               end else if (req_chan.last) begin
                  state_in = rfcs_pkg::ST_MEAN_LOAD;
               end
            end
         end

         rfcs_pkg::ST_MUL_RED: begin
            mul_a       = rfcs_pkg::MUL_W'(red_ff);
            mul_b       = rfcs_pkg::LUMA_W_RED;
            prod_in     = mul_out;
            luma_acc_in = rfcs_pkg::LUMA_ROUND;
            state_in    = rfcs_pkg::ST_MUL_GREEN;
         end

         rfcs_pkg::ST_MUL_GREEN: begin
            mul_a       = rfcs_pkg::MUL_W'(green_ff);
            mul_b       = rfcs_pkg::LUMA_W_GREEN;
            prod_in     = mul_out;
            luma_acc_in = luma_acc_ff + prod_ff[rfcs_pkg::MUL_W-1:0];
            state_in    = rfcs_pkg::ST_MUL_BLUE;
         end

         rfcs_pkg::ST_MUL_BLUE: begin
            mul_a       = rfcs_pkg::MUL_W'(blue_ff);
            mul_b       = rfcs_pkg::LUMA_W_BLUE;
            prod_in     = mul_out;
            luma_acc_in = luma_acc_ff + prod_ff[rfcs_pkg::MUL_W-1:0];
            state_in    = rfcs_pkg::ST_LUMA;
         end

         rfcs_pkg::ST_LUMA: begin
            luma_acc_in = luma_acc_ff + prod_ff[rfcs_pkg::MUL_W-1:0];
            state_in    = rfcs_pkg::ST_SQUARE;
         end

         rfcs_pkg::ST_SQUARE: begin
            // Square the luma and add the first terms of the pixel
            mul_a       = rfcs_pkg::MUL_W'(luma_acc_ff[rfcs_pkg::MUL_W-1:rfcs_pkg::CHAN_W]);
            mul_b       = rfcs_pkg::MUL_W'(luma_acc_ff[rfcs_pkg::MUL_W-1:rfcs_pkg::CHAN_W]);
            prod_in     = mul_out;
            sum_red_in  = sum_red_ff + rfcs_pkg::SUM_RED_W'(red_ff);
            sum_gb_in   = sum_gb_ff + rfcs_pkg::SUM_GB_W'(green_ff);
            sum_luma_in = sum_luma_ff
                        + rfcs_pkg::SUM_LUMA_W'(luma_acc_ff[rfcs_pkg::MUL_W-1:rfcs_pkg::CHAN_W]);
            state_in    = rfcs_pkg::ST_ACCUM;
         end

         rfcs_pkg::ST_ACCUM: begin
            sum_gb_in = sum_gb_ff + rfcs_pkg::SUM_GB_W'(blue_ff);
            sum_sq_in = sum_sq_ff + prod_ff[rfcs_pkg::SUM_SQ_W-1:0];
            count_in  = count_ff + rfcs_pkg::COUNT_W'(1);
            state_in  = last_ff ? rfcs_pkg::ST_MEAN_LOAD : rfcs_pkg::ST_IDLE;
         end

         rfcs_pkg::ST_MEAN_LOAD: begin
            // Load sum_red + n/2 over n
            div_quo_in = rfcs_pkg::DIV_W'(sum_red_ff)
                       + rfcs_pkg::DIV_W'(count_ff[rfcs_pkg::COUNT_W-1:1]);
            div_rem_in = '0;
            div_den_in = rfcs_pkg::DEN_W'(count_ff);
            div_cnt_in = rfcs_pkg::DIV_CNT_W'(rfcs_pkg::DIV_W - 1);
            state_in   = rfcs_pkg::ST_MEAN_RUN;
         end

         rfcs_pkg::ST_MEAN_RUN: begin
            div_quo_in = div_quo_step;
            div_rem_in = div_rem_step;
            div_cnt_in = div_cnt_ff - rfcs_pkg::DIV_CNT_W'(1);
            if (div_done) begin
               state_in = rfcs_pkg::ST_RATIO_PREP;
            end
         end

         rfcs_pkg::ST_RATIO_PREP: begin
            // Hold the saturated mean and form the ratio denominator
            mean_in    = (|div_quo_ff[rfcs_pkg::DIV_W-1:rfcs_pkg::RED_MEAN_W])
                       ? '1 : div_quo_ff[rfcs_pkg::RED_MEAN_W-1:0];
            div_den_in = rfcs_pkg::DEN_W'(sum_gb_ff) + rfcs_pkg::RATIO_ONE;
            state_in   = rfcs_pkg::ST_RATIO_LOAD;
         end

         rfcs_pkg::ST_RATIO_LOAD: begin
            div_quo_in = rfcs_pkg::DIV_W'({sum_red_ff, rfcs_pkg::RATIO_FRAC_W'(0)})
                       + rfcs_pkg::DIV_W'(div_den_ff[rfcs_pkg::DEN_W-1:1]);
            div_rem_in = '0;
            div_cnt_in = rfcs_pkg::DIV_CNT_W'(rfcs_pkg::DIV_W - 1);
            state_in   = rfcs_pkg::ST_RATIO_RUN;
         end

         rfcs_pkg::ST_RATIO_RUN: begin
            div_quo_in = div_quo_step;
            div_rem_in = div_rem_step;
            div_cnt_in = div_cnt_ff - rfcs_pkg::DIV_CNT_W'(1);
            if (div_done) begin
               state_in = rfcs_pkg::ST_RATIO_DONE;
            end
         end

         rfcs_pkg::ST_RATIO_DONE: begin
            // Hold the saturated ratio; a single pixel has zero variance
            ratio_in = (|div_quo_ff[rfcs_pkg::DIV_W-1:rfcs_pkg::RED_OVER_GB_W])
                     ? '1 : div_quo_ff[rfcs_pkg::RED_OVER_GB_W-1:0];
            if (count_ff > rfcs_pkg::COUNT_W'(1)) begin
               state_in = rfcs_pkg::ST_VAR_S1SQ;
            end else begin
               var_in   = '0;
               state_in = rfcs_pkg::ST_EMIT;
            end
         end

         rfcs_pkg::ST_VAR_S1SQ: begin
            mul_a    = sum_luma_ff;
            mul_b    = sum_luma_ff;
            prod_in  = mul_out;
            state_in = rfcs_pkg::ST_VAR_NLO;
         end

         rfcs_pkg::ST_VAR_NLO: begin
            // Split n*S2 into two partial products
            var_s_in = prod_ff;
            mul_a    = rfcs_pkg::MUL_W'(count_ff);
            mul_b    = rfcs_pkg::MUL_W'(sum_sq_ff[rfcs_pkg::SQ_HALF_W-1:0]);
            prod_in  = mul_out;
            state_in = rfcs_pkg::ST_VAR_NHI;
         end

         rfcs_pkg::ST_VAR_NHI: begin
            var_a_in = prod_ff;
            mul_a    = rfcs_pkg::MUL_W'(count_ff);
            mul_b    = rfcs_pkg::MUL_W'(sum_sq_ff[rfcs_pkg::SUM_SQ_W-1:rfcs_pkg::SQ_HALF_W]);
            prod_in  = mul_out;
            state_in = rfcs_pkg::ST_VAR_SUMA;
         end

         rfcs_pkg::ST_VAR_SUMA: begin
            var_a_in = var_a_ff + {prod_ff[rfcs_pkg::DIV_W-rfcs_pkg::SQ_HALF_W-1:0],
                                   rfcs_pkg::SQ_HALF_W'(0)};
            state_in = rfcs_pkg::ST_VAR_NN;
         end

         rfcs_pkg::ST_VAR_NN: begin
            mul_a    = rfcs_pkg::MUL_W'(count_ff);
            mul_b    = rfcs_pkg::MUL_W'(count_ff - rfcs_pkg::COUNT_W'(1));
            prod_in  = mul_out;
            state_in = rfcs_pkg::ST_VAR_DIFF;
         end

         rfcs_pkg::ST_VAR_DIFF: begin
            // Take n*S2 - S1^2 and n*(n-1)*256
            var_a_in   = var_sub[rfcs_pkg::DIV_W-1:0];
            var_neg_in = var_sub[rfcs_pkg::DIV_W];
            div_den_in = {prod_ff[rfcs_pkg::DEN_W-rfcs_pkg::VAR_SCALE_W-1:0],
                          rfcs_pkg::VAR_SCALE_W'(0)};
            state_in   = rfcs_pkg::ST_VAR_LOAD;
         end

         rfcs_pkg::ST_VAR_LOAD: begin
            if (var_neg_ff) begin
               var_in   = '0;
               state_in = rfcs_pkg::ST_EMIT;
            end else begin
               div_quo_in = var_a_ff + rfcs_pkg::DIV_W'(div_den_ff[rfcs_pkg::DEN_W-1:1]);
               div_rem_in = '0;
               div_cnt_in = rfcs_pkg::DIV_CNT_W'(rfcs_pkg::DIV_W - 1);
               state_in   = rfcs_pkg::ST_VAR_RUN;
            end
         end

         rfcs_pkg::ST_VAR_RUN: begin
            div_quo_in = div_quo_step;
            div_rem_in = div_rem_step;
            div_cnt_in = div_cnt_ff - rfcs_pkg::DIV_CNT_W'(1);
            if (div_done) begin
               state_in = rfcs_pkg::ST_VAR_DONE;
            end
         end

         rfcs_pkg::ST_VAR_DONE: begin
            var_in   = (|div_quo_ff[rfcs_pkg::DIV_W-1:rfcs_pkg::LUMA_VAR_W])
                     ? '1 : div_quo_ff[rfcs_pkg::LUMA_VAR_W-1:0];
            state_in = rfcs_pkg::ST_EMIT;
         end

         rfcs_pkg::ST_EMIT: begin
            // Hold until the response register is free, then clear the frame
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_mean_in  = mean_ff;
               rsp_ratio_in = ratio_ff;
               rsp_var_in   = var_ff;
               rsp_total_in = rfcs_pkg::PIXEL_TOTAL_W'(count_ff);
               count_in     = '0;
               sum_red_in   = '0;
               sum_gb_in    = '0;
               sum_luma_in  = '0;
               sum_sq_in    = '0;
               state_in     = rfcs_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = rfcs_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state and accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rfcs_pkg::ST_IDLE;
         count_ff     <= '0;
         sum_red_ff   <= '0;
         sum_gb_ff    <= '0;
         sum_luma_ff  <= '0;
         sum_sq_ff    <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_red_ff   <= sum_red_in;
         sum_gb_ff    <= sum_gb_in;
         sum_luma_ff  <= sum_luma_in;
         sum_sq_ff    <= sum_sq_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath and payload registers
   always_ff @(posedge clock) begin
      red_ff       <= red_in;
      green_ff     <= green_in;
      blue_ff      <= blue_in;
      last_ff      <= last_in;
      luma_acc_ff  <= luma_acc_in;
      prod_ff      <= prod_in;
      div_quo_ff   <= div_quo_in;
      div_rem_ff   <= div_rem_in;
      div_den_ff   <= div_den_in;
      var_a_ff     <= var_a_in;
      var_s_ff     <= var_s_in;
      var_neg_ff   <= var_neg_in;
      mean_ff      <= mean_in;
      ratio_ff     <= ratio_in;
      var_ff       <= var_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_ratio_ff <= rsp_ratio_in;
      rsp_var_ff   <= rsp_var_in;
      rsp_total_ff <= rsp_total_in;
   end

   // Drive the response channel
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.red_mean      = rsp_mean_ff;
   assign rsp_chan.red_over_gb   = rsp_ratio_ff;
   assign rsp_chan.luma_variance = rsp_var_ff;
   assign rsp_chan.pixel_total   = rsp_total_ff;

endmodule

// File: hdl/rfcs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB565 frame statistics checker
// Port-level assertions on the request and response channels over time.
// ----------------------------------------------------------------------------
`include "rgb565_frame_color_statistics_macros.svh"

module rfcs_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_last,
   input logic rsp_valid,
   input logic rsp_ready
);

   // A stalled response stays offered
   `RFCS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

   // Reset leaves no response pending
   `RFCS_ASSERT_NEXT_ALWAYS(a_rsp_reset, clock, reset, !rsp_valid, "response valid after reset")

   // A new response only appears after a busy frame close
   `RFCS_ASSERT_SAME(a_rsp_after_close, clock, reset, $rose(rsp_valid), $past(!req_ready), "response without frame close")

   // Closing a frame always takes the block busy
   `RFCS_ASSERT_NEXT(a_last_busy, clock, reset, req_valid && req_ready && req_last, !req_ready, "ready after last pixel")

endmodule

bind rgb565_frame_color_statistics rfcs_checker u_rfcs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_last  (req_chan.last),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready)
);

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB565 frame color statistics testbench
// Streams frames of RGB565 pixels through the block and checks every frame
// response against a bit-exact predictor of the red mean, red ratio, luma
// variance and pixel count. A short directed table covers the channel
// extremes, saturation and single-pixel frames. Random frames follow, with
// random idling on both channels, a long response hold-off and a pause that
// lets the response queue drain.
// ----------------------------------------------------------------------------
module tb;

   // Run control
   localparam int  LONG_HOLD    = 2500;
   localparam int  DRAIN_CYCLES = 300;
   localparam int  RANDOM_ITEMS = 430;
   localparam int  CALM_ITEMS   = 80;
   localparam longint CYCLE_LIMIT = 1500000;

   // Fixed-point constants of the color math
   localparam longint Q88_FULL   = 65280;
   localparam longint WEIGHT_R   = 19595;
   localparam longint WEIGHT_G   = 38470;
   localparam longint WEIGHT_B   = 7471;
   localparam longint LUMA_HALF  = 32768;
   localparam longint RATIO_BIAS = 256;
   localparam longint MEAN_SAT   = 64'hFFFF;
   localparam longint RATIO_SAT  = 64'hFF_FFFF;
   localparam longint VAR_SAT    = 64'h7F_FFFF;

   typedef struct packed {
      logic [rfcs_pkg::RED_MEAN_W-1:0]    red_mean;
      logic [rfcs_pkg::RED_OVER_GB_W-1:0] red_over_gb;
      logic [rfcs_pkg::LUMA_VAR_W-1:0]    luma_variance;
      logic [rfcs_pkg::PIXEL_TOTAL_W-1:0] pixel_total;
   } frame_stats_type;

   typedef struct packed {
      logic [rfcs_pkg::PIXEL_W-1:0] pixel;
      logic                         last;
      logic                         typed;
      frame_stats_type              stats;
   } pixel_row_type;

   localparam frame_stats_type NO_STATS = '0;

   // Directed table: typed stats only where they follow at a glance
   localparam int DIRECTED_ROWS = 16;
   localparam pixel_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{16'h0000, 1'b1, 1'b1, '{16'h0000, 24'h00_0000, 23'd0, 16'd1}},
      '{16'hF800, 1'b1, 1'b1, '{16'hFF00, 24'hFF_0000, 23'd0, 16'd1}},
      '{16'hF800, 1'b0, 1'b0, '0},
      '{16'hF800, 1'b1, 1'b1, '{16'hFF00, 24'hFF_FFFF, 23'd0, 16'd2}},
      '{16'h07E0, 1'b1, 1'b1, '{16'h0000, 24'h00_0000, 23'd0, 16'd1}},
      '{16'h001F, 1'b1, 1'b1, '{16'h0000, 24'h00_0000, 23'd0, 16'd1}},
      '{16'h0000, 1'b0, 1'b0, '0},
      '{16'hFFFF, 1'b1, 1'b0, '0},
      '{16'hFFFF, 1'b1, 1'b0, '0},
      '{16'hAAAA, 1'b0, 1'b0, '0},
      '{16'h5555, 1'b0, 1'b0, '0},
      '{16'h0821, 1'b1, 1'b0, '0},
      '{16'hF7DE, 1'b0, 1'b0, '0},
      '{16'h0000, 1'b0, 1'b0, '0},
      '{16'hFFFF, 1'b0, 1'b0, '0},
      '{16'hFFFF, 1'b1, 1'b0, '0}
   };

   logic clock;
   logic reset;

   rfcs_req_if req_chan ();
   rfcs_rsp_if rsp_chan ();

   rgb565_frame_color_statistics u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   // Predictor state: running sums of the open frame
   longint       frame_count;
   bit [63:0]    acc_red;
   bit [63:0]    acc_green_blue;
   bit [63:0]    acc_luma;
   bit [63:0]    acc_luma_sq;

   frame_stats_type frames_expected [$];
   int              mismatches;
   longint          cycle_count;
   int              idle_pct;
   bit              calm;
   int              long_hold_left;

   // Clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic bit [63:0] round_div(input bit [63:0] num, input bit [63:0] den);
      if (den == 0)
         return 0;
      return (num + den / 2) / den;
   endfunction

   // Fold one accepted pixel into the sums; close the frame on last
   task automatic fold_pixel(input logic [rfcs_pkg::PIXEL_W-1:0] pixel,
                             input logic last_flag,
                             output bit closes, output frame_stats_type stats);
      bit [63:0] red;
      bit [63:0] green;
      bit [63:0] blue;
      bit [63:0] luma;
      bit [63:0] n;
      bit [63:0] mean;
      bit [63:0] ratio;
      bit [63:0] variance;
      bit [63:0] n_s2;
      bit [63:0] s1_sq;
      closes = 1'b0;
      stats  = NO_STATS;
      if (frame_count < rfcs_pkg::MAX_PIXELS) begin
         red   = (64'(pixel[15:11]) * Q88_FULL + 15) / 31;
         green = (64'(pixel[10:5]) * Q88_FULL + 31) / 63;
         blue  = (64'(pixel[4:0]) * Q88_FULL + 15) / 31;
         luma  = (WEIGHT_R * red + WEIGHT_G * green + WEIGHT_B * blue + LUMA_HALF) >> 16;
         acc_red        = (acc_red + red) & 64'hFFFF_FFFF;
         acc_green_blue = (acc_green_blue + green + blue) & 64'h1_FFFF_FFFF;
         acc_luma       = (acc_luma + luma) & 64'hFFFF_FFFF;
         acc_luma_sq    = (acc_luma_sq + luma * luma) & 64'hFFFF_FFFF_FFFF;
         frame_count++;
      end
      if (!last_flag)
         return;

      n        = 64'(frame_count);
      mean     = round_div(acc_red, n);
      ratio    = round_div(acc_red << 16, acc_green_blue + RATIO_BIAS);
      variance = 0;
      if (mean > MEAN_SAT)
         mean = MEAN_SAT;
      if (ratio > RATIO_SAT)
         ratio = RATIO_SAT;
      // One pixel, or sums that no longer agree, leave the variance at zero
      if (n > 1) begin
         n_s2  = n * acc_luma_sq;
         s1_sq = acc_luma * acc_luma;
         if (n_s2 >= s1_sq) begin
            variance = round_div(n_s2 - s1_sq, n * (n - 1) * 256);
            if (variance > VAR_SAT)
               variance = VAR_SAT;
         end
      end
      stats.red_mean      = rfcs_pkg::RED_MEAN_W'(mean);
      stats.red_over_gb   = rfcs_pkg::RED_OVER_GB_W'(ratio);
      stats.luma_variance = rfcs_pkg::LUMA_VAR_W'(variance);
      stats.pixel_total   = rfcs_pkg::PIXEL_TOTAL_W'(n);
      closes = 1'b1;

      frame_count    = 0;
      acc_red        = 0;
      acc_green_blue = 0;
      acc_luma       = 0;
      acc_luma_sq    = 0;
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatches++;
   endtask

   // Offer one request from a falling edge; return at the falling edge after acceptance
   task automatic send_pixel(input logic [rfcs_pkg::PIXEL_W-1:0] pixel,
                             input logic last_flag,
                             input logic typed, input frame_stats_type typed_stats);
      frame_stats_type stats;
      bit              closes;
      int              gap;
      if (!calm && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 12);
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.pixel <= pixel;
      req_chan.last  <= last_flag;
      do
         @(posedge clock);
      while (!req_chan.ready);
      fold_pixel(pixel, last_flag, closes, stats);
      if (closes)
         frames_expected.push_back(typed ? typed_stats : stats);
      @(negedge clock);
   endtask

   function automatic logic [rfcs_pkg::PIXEL_W-1:0] random_pixel();
      case ($urandom_range(0, 9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'hF800;
         3:       return ($urandom_range(0, 1) != 0) ? 16'h07E0 : 16'h001F;
         default: return rfcs_pkg::PIXEL_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // Mostly short frames, a few longer ones
   function automatic int random_frame_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         return $urandom_range(1, 6);
      if (pick < 95)
         return $urandom_range(7, 30);
      return $urandom_range(31, 80);
   endfunction

   task automatic send_frame(input int length);
      int k;
      for (k = 0; k < length; k++)
         send_pixel(random_pixel(), k == length - 1, 1'b0, NO_STATS);
   endtask

   // Response ready: random stall bursts, a long hold on request, none when calm
   initial begin
      int stall_left;
      stall_left     = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            long_hold_left--;
         end else if (calm) begin
            rsp_chan.ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            stall_left     = $urandom_range(1, 12) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Compare each accepted response with the oldest expected frame
   always @(posedge clock) begin
      frame_stats_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (frames_expected.size() == 0) begin
            report_mismatch("response with no frame pending", rsp_chan.pixel_total, 0);
         end else begin
            want = frames_expected.pop_front();
            if (rsp_chan.red_mean !== want.red_mean)
               report_mismatch("red_mean", rsp_chan.red_mean, want.red_mean);
            if (rsp_chan.red_over_gb !== want.red_over_gb)
               report_mismatch("red_over_gb", rsp_chan.red_over_gb, want.red_over_gb);
            if (rsp_chan.luma_variance !== want.luma_variance)
               report_mismatch("luma_variance", rsp_chan.luma_variance,
                               want.luma_variance);
            if (rsp_chan.pixel_total !== want.pixel_total)
               report_mismatch("pixel_total", rsp_chan.pixel_total, want.pixel_total);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Stimulus
   initial begin
      int k;
      int sent;
      int length;
      bit hold_done;
      bit pause_done;

      mismatches     = 0;
      cycle_count    = 0;
      idle_pct       = 0;
      calm           = 1'b0;
      long_hold_left = 0;
      hold_done      = 1'b0;
      pause_done     = 1'b0;
      frame_count    = 0;
      acc_red        = 0;
      acc_green_blue = 0;
      acc_luma       = 0;
      acc_luma_sq    = 0;
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.pixel = '0;
      req_chan.last  = 1'b0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table
      idle_pct = 20;
      for (k = 0; k < DIRECTED_ROWS; k++)
         send_pixel(DIRECTED[k].pixel, DIRECTED[k].last, DIRECTED[k].typed,
                    DIRECTED[k].stats);

      // Random frames
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent >= RANDOM_ITEMS - CALM_ITEMS) begin
            calm = 1'b1;
         end else begin
            case ($urandom_range(0, 3))
               0:       idle_pct = 0;
               1:       idle_pct = 10;
               2:       idle_pct = 30;
               default: idle_pct = 60;
            endcase
         end
         // Hold off responses for a long stretch while requests keep coming
         if (!hold_done && sent >= 150) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
            long_hold_left = LONG_HOLD;
            @(negedge clock);
            hold_done = 1'b1;
         end
         // Pause requests until every pending frame has been answered
         if (!pause_done && sent >= 300) begin
            req_chan.valid <= 1'b0;
            while (frames_expected.size() != 0)
               @(posedge clock);
            @(negedge clock);
            pause_done = 1'b1;
         end
         length = random_frame_length();
         send_frame(length);
         sent += length;
      end

      req_chan.valid <= 1'b0;
      while (frames_expected.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: rgb565_frame_color_statistics.f
+incdir+hdl
hdl/rfcs_pkg.sv
hdl/rfcs_req_if.sv
hdl/rfcs_rsp_if.sv
hdl/rgb565_frame_color_statistics.sv
hdl/rfcs_checker.sv
tb/sv/tb.sv
